// File: hdl/pap_pkg.sv
`default_nettype none

package pap_pkg;

  // Coordinate width of the vertex fields (signed, 8 fraction bits).
  localparam int COORD_BITS = 20;
  localparam int MAX_VERTICES = 4096;

  // Shared multiplier operands carry one extra bit so that a coordinate
  // difference magnitude fits as a non-negative signed value.
  localparam int MUL_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int TERM_W = PROD_W + 1;
  localparam int ROOT_W = COORD_BITS + 1;
  localparam int RAD_W = 2 * ROOT_W;
  localparam int CROSS_W = 53;
  localparam int AREA_W = 52;
  localparam int LEN_W = 33;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_coord;
    logic signed [COORD_BITS-1:0] y_coord;
    logic                         last_vertex;
  } pap_in_t;

  typedef struct packed {
    logic signed [AREA_W-1:0] signed_area;
    logic        [LEN_W-1:0]  perimeter;
    logic                     too_many_vertices;
  } pap_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_Q,
    ST_MUL_DX,
    ST_MUL_DY,
    ST_SQ_LOAD,
    ST_SQRT_RUN,
    ST_FINISH,
    ST_EMIT
  } pap_state_e;

  typedef enum logic [1:0] {
    MUL_AX_BY,
    MUL_AY_BX,
    MUL_DX_DX,
    MUL_DY_DY
  } pap_mul_op_e;

  typedef struct packed {
    logic        load;
    logic        close_sel;
    pap_mul_op_e mul_op;
    logic        diff_en;
    logic        p_en;
    logic        term_en;
    logic        cross_en;
    logic        sqx_en;
    logic        sqrt_start;
    logic        len_en;
    logic        finish;
    logic        emit;
  } pap_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic sqrt_busy;
    logic out_free;
  } pap_stat_t;

endpackage

`default_nettype wire

// File: hdl/pap_isqrt.sv
`default_nettype none

module pap_isqrt import pap_pkg::*; #(
  parameter int RootW = ROOT_W
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [2*RootW-1:0] radicand_i,
  output logic                    busy_o,
  output logic [RootW-1:0]        root_o
);

  localparam int CntW = $clog2(RootW + 1);

  logic [2*RootW-1:0] rad_q;
  logic [RootW+1:0]   rem_q;
  logic [RootW-1:0]   root_q;
  logic [CntW-1:0]    cnt_q;
  logic               busy_q;

  logic [RootW+1:0] rem_next;
  logic [RootW+1:0] trial;
  logic             fits;

  // One result bit per cycle: bring down the next two radicand bits and try
  // the partial root with a one appended.
  always_comb begin
    rem_next = {rem_q[RootW-1:0], rad_q[2*RootW-1 -: 2]};
    trial    = {root_q, 2'b01};
    fits     = (rem_next >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(RootW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[2*RootW-3:0], 2'b00};
      rem_q  <= fits ? (rem_next - trial) : rem_next;
      root_q <= {root_q[RootW-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

// File: hdl/pap_datapath.sv
`default_nettype none

module pap_datapath import pap_pkg::*; #(
  parameter int MaxVertices = MAX_VERTICES
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire pap_in_t  in_item_i,
  input  wire pap_cmd_t cmd_i,
  output pap_stat_t     stat_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output pap_out_t      out_item_o
);

  localparam int CntW = $clog2(MaxVertices + 1);
  localparam logic signed [CROSS_W-1:0] CrossMax = {1'b0, {(CROSS_W-1){1'b1}}};
  localparam logic signed [CROSS_W-1:0] CrossMin = {1'b1, {(CROSS_W-1){1'b0}}};
  localparam logic signed [AREA_W-1:0]  AreaMax  = {1'b0, {(AREA_W-1){1'b1}}};
  localparam logic signed [AREA_W-1:0]  AreaMin  = {1'b1, {(AREA_W-1){1'b0}}};

  // Vertex registers.
  logic signed [COORD_BITS-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q;
  // Accumulators and counters.
  logic signed [CROSS_W-1:0] cross_q, cross_d;
  logic        [LEN_W-1:0]   len_q, len_d;
  logic        [CntW-1:0]    count_q;
  logic                      ovf_q;
  // Edge working registers.
  logic        [COORD_BITS-1:0] dx_q, dy_q;
  logic signed [PROD_W-1:0]     prod_q, prod_d;
  logic signed [PROD_W-1:0]     p_q;
  logic signed [TERM_W-1:0]     term_q;
  logic        [RAD_W-1:0]      sqx_q;
  // Output register.
  pap_out_t out_q;
  logic     out_valid_q;

  logic signed [COORD_BITS-1:0] ax, ay, bx, by;
  logic signed [MUL_W-1:0]      diff_x, diff_y, mul_a, mul_b;
  logic        [COORD_BITS-1:0] dx_d, dy_d;
  logic signed [CROSS_W:0]      cross_sum;
  logic        [LEN_W:0]        len_sum;
  logic        [RAD_W-1:0]      radicand;
  logic signed [AREA_W-1:0]     area;
  logic                         count_full;
  logic                         sqrt_busy;
  logic        [ROOT_W-1:0]     root;

  // Edge runs from a to b: previous to current, or current back to first.
  always_comb begin
    if (cmd_i.close_sel) begin
      ax = cur_x_q;
      ay = cur_y_q;
      bx = first_x_q;
      by = first_y_q;
    end else begin
      ax = prev_x_q;
      ay = prev_y_q;
      bx = cur_x_q;
      by = cur_y_q;
    end
    diff_x = MUL_W'(ax) - MUL_W'(bx);
    diff_y = MUL_W'(ay) - MUL_W'(by);
    dx_d   = diff_x[MUL_W-1] ? COORD_BITS'(-diff_x) : COORD_BITS'(diff_x);
    dy_d   = diff_y[MUL_W-1] ? COORD_BITS'(-diff_y) : COORD_BITS'(diff_y);
  end

  // One shared multiplier, registered.
  always_comb begin
    case (cmd_i.mul_op)
      MUL_AX_BY: begin
        mul_a = MUL_W'(ax);
        mul_b = MUL_W'(by);
      end
      MUL_AY_BX: begin
        mul_a = MUL_W'(ay);
        mul_b = MUL_W'(bx);
      end
      MUL_DX_DX: begin
        mul_a = $signed({1'b0, dx_q});
        mul_b = $signed({1'b0, dx_q});
      end
      MUL_DY_DY: begin
        mul_a = $signed({1'b0, dy_q});
        mul_b = $signed({1'b0, dy_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = mul_a * mul_b;
  end

  always_comb begin
    cross_sum = (CROSS_W+1)'(cross_q) + (CROSS_W+1)'(term_q);
    if (cross_sum[CROSS_W] != cross_sum[CROSS_W-1]) begin
      cross_d = cross_sum[CROSS_W] ? CrossMin : CrossMax;
    end else begin
      cross_d = cross_sum[CROSS_W-1:0];
    end

    len_sum = (LEN_W+1)'(len_q) + (LEN_W+1)'(root);
    len_d   = len_sum[LEN_W] ? {LEN_W{1'b1}} : len_sum[LEN_W-1:0];

    radicand = sqx_q + $unsigned(prod_q);

    if (cross_q[CROSS_W-1] != cross_q[CROSS_W-2]) begin
      area = cross_q[CROSS_W-1] ? AreaMin : AreaMax;
    end else begin
      area = cross_q[AREA_W-1:0];
    end

    count_full = (count_q == CntW'(MaxVertices));
  end

  pap_isqrt #(
    .RootW(ROOT_W)
  ) u_isqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.sqrt_start),
    .radicand_i(radicand),
    .busy_o    (sqrt_busy),
    .root_o    (root)
  );

  // Polygon state; cleared when the result is loaded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_x_q <= '0;
      first_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      cross_q   <= '0;
      len_q     <= '0;
      count_q   <= '0;
      ovf_q     <= 1'b0;
    end else if (cmd_i.emit) begin
      first_x_q <= '0;
      first_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      cross_q   <= '0;
      len_q     <= '0;
      count_q   <= '0;
      ovf_q     <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        if (count_q == '0) begin
          first_x_q <= in_item_i.x_coord;
          first_y_q <= in_item_i.y_coord;
        end
        if (count_full) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + 1'b1;
        end
      end
      if (cmd_i.finish) begin
        prev_x_q <= cur_x_q;
        prev_y_q <= cur_y_q;
      end
      if (cmd_i.cross_en) begin
        cross_q <= cross_d;
      end
      if (cmd_i.len_en) begin
        len_q <= len_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.load) begin
      cur_x_q <= in_item_i.x_coord;
      cur_y_q <= in_item_i.y_coord;
    end
    if (cmd_i.diff_en) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
    if (cmd_i.p_en) begin
      p_q <= prod_q;
    end
    if (cmd_i.term_en) begin
      term_q <= TERM_W'(p_q) - TERM_W'(prod_q);
    end
    if (cmd_i.sqx_en) begin
      sqx_q <= $unsigned(prod_q);
    end
    if (cmd_i.emit) begin
      out_q.signed_area       <= area;
      out_q.perimeter         <= len_q;
      out_q.too_many_vertices <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.sqrt_busy  = sqrt_busy;
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_item_o        = out_q;

endmodule

`default_nettype wire

// File: hdl/pap_ctrl.sv
`default_nettype none

module pap_ctrl import pap_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_last_i,
  output logic           in_stall_o,
  input  wire pap_stat_t stat_i,
  output pap_cmd_t       cmd_o
);

  pap_state_e state_q, state_d;
  logic       close_q, close_d;
  logic       last_q, last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      close_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      close_q <= close_d;
      last_q  <= last_d;
    end
  end

  always_comb begin
    state_d = state_q;
    close_d = close_q;
    last_d  = last_q;
    cmd_o   = '0;
    cmd_o.close_sel = close_q;
    cmd_o.mul_op    = MUL_AX_BY;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          last_d     = in_last_i;
          // The first vertex opens no edge; if it is also the last, only the
          // (zero length) closing edge remains.
          if (stat_i.count_zero) begin
            close_d = in_last_i;
            state_d = in_last_i ? ST_MUL_P : ST_FINISH;
          end else begin
            close_d = 1'b0;
            state_d = ST_MUL_P;
          end
        end
      end
      ST_MUL_P: begin
        cmd_o.mul_op  = MUL_AX_BY;
        cmd_o.diff_en = 1'b1;
        state_d       = ST_MUL_Q;
      end
      ST_MUL_Q: begin
        cmd_o.mul_op = MUL_AY_BX;
        cmd_o.p_en   = 1'b1;
        state_d      = ST_MUL_DX;
      end
      ST_MUL_DX: begin
        cmd_o.mul_op  = MUL_DX_DX;
        cmd_o.term_en = 1'b1;
        state_d       = ST_MUL_DY;
      end
      ST_MUL_DY: begin
        cmd_o.mul_op   = MUL_DY_DY;
        cmd_o.sqx_en   = 1'b1;
        cmd_o.cross_en = 1'b1;
        state_d        = ST_SQ_LOAD;
      end
      ST_SQ_LOAD: begin
        cmd_o.sqrt_start = 1'b1;
        state_d          = ST_SQRT_RUN;
      end
      ST_SQRT_RUN: begin
        if (!stat_i.sqrt_busy) begin
          cmd_o.len_en = 1'b1;
          if (last_q && !close_q) begin
            close_d = 1'b1;
            state_d = ST_MUL_P;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = last_q ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// File: hdl/polygon_area_perimeter_unit.sv
`default_nettype none

// Channel   Direction  Handshake                 Item
// in        input      in_valid_i / in_stall_o   pap_in_t: one vertex, last flag
// out       output     out_valid_o / out_stall_i pap_out_t: area, perimeter, flag
//
// A vertex after the first runs its edge through MUL_P, MUL_Q, MUL_DX, MUL_DY,
// SQ_LOAD, SQRT_RUN and FINISH before the next is taken; the first goes to FINISH
// at once, and the last also runs the closing edge, then EMIT, longer while an
// earlier result waits. Each edge costs four passes through the one shared
// multiplier and a run of the bit-serial square root, which sets the rate.
// Reset clears the polygon state and leaves the output empty.
// A stalled result holds in the output register while the next polygon is taken.

module polygon_area_perimeter_unit import pap_pkg::*; #(
  parameter int MaxVertices = MAX_VERTICES
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire pap_in_t in_item_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output pap_out_t     out_item_o
);

  pap_cmd_t  cmd;
  pap_stat_t stat;

  pap_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_last_i (in_item_i.last_vertex),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  pap_datapath #(
    .MaxVertices(MaxVertices)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire
